// ----- src/oversampled_half_duplex_soft_uart_top_defines.svh -----
// assertion macros shared by the soft uart rtl
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef OVERSAMPLED_HALF_DUPLEX_SOFT_UART_TOP_DEFINES_SVH
`define OVERSAMPLED_HALF_DUPLEX_SOFT_UART_TOP_DEFINES_SVH

// condition holds on every clock outside reset
`define OHSU_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("soft uart assertion failed");

// same-cycle implication
`define OHSU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("soft uart assertion failed");

// next-cycle implication
`define OHSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("soft uart assertion failed");

`endif

// ----- src/ohsu_pkg.sv -----
// types, constants and helper functions for the half-duplex soft uart
// no dependencies; used by every rtl file of the block
`default_nettype none

package ohsu_pkg;

    // sizing
    localparam int TX_DEPTH        = 16;
    localparam int SAMPLES_PER_BIT = 3;
    localparam int CNT_W  = $clog2(TX_DEPTH + 1);
    localparam int ADDR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int SC_W   = $clog2(SAMPLES_PER_BIT + 1);
    localparam int HIST_W = SAMPLES_PER_BIT;

    localparam logic [CNT_W-1:0] TX_DEPTH_N = CNT_W'(TX_DEPTH);
    localparam logic [SC_W-1:0]  SPB_N      = SC_W'(SAMPLES_PER_BIT);
    localparam logic [2:0]       LAST_BIT   = 3'd7;

    // function codes
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_TX   = 2'd1;
    localparam logic [1:0] FUNC_RX   = 2'd2;

    // line phase, shared by transmit and receive
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_STOP  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       rx_line;
    } t_in_item;

    typedef struct packed {
        logic        tx_line;
        logic        tx_active;
        logic        tx_done;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic [15:0] rx_total;
        logic        rx_enabled;
    } t_out_item;

    // majority vote, a tie decides low
    function automatic logic vote(input logic [HIST_W-1:0] hist);
        logic [SC_W-1:0] ones;
        ones = '0;
        for (int i = 0; i < HIST_W; i++) begin
            ones = ones + SC_W'(hist[i]);
        end
        return ({ones, 1'b0} > (SC_W + 1)'(SAMPLES_PER_BIT));
    endfunction

endpackage

`default_nettype wire

// ----- src/oversampled_half_duplex_soft_uart_top.sv -----
// half-duplex 8n1 soft uart with majority-vote oversampling, top level
// the result of a beat is registered in the output buffer when the beat is accepted
// throughput: one beat per cycle while the input is not stalled; state updates in a single pass per beat
// a two-entry output buffer keeps input flowing while one result waits
// reset: synchronous active low, clears all control state, line idles high
`default_nettype none

module oversampled_half_duplex_soft_uart_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire ohsu_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output ohsu_pkg::t_out_item      o_out_item
);

    logic                in_fire;
    ohsu_pkg::t_out_item result;

    // input beat accepted
    assign in_fire = i_in_valid && !o_in_stall;

    ohsu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_item   (i_in_item),
        .o_result (result)
    );

    ohsu_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_fire),
        .i_data  (result),
        .o_stall (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- src/ohsu_core.sv -----
// soft uart state and per-beat update: transmit buffer, tx serializer, rx voter
// depends on ohsu_pkg and the defines header
`default_nettype none
`include "oversampled_half_duplex_soft_uart_top_defines.svh"

module ohsu_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire ohsu_pkg::t_in_item i_item,
    output ohsu_pkg::t_out_item     o_result
);

    logic [7:0] r_tx_buffer [ohsu_pkg::TX_DEPTH];

    logic [ohsu_pkg::CNT_W-1:0]  r_load_count, n_load_count;
    logic [ohsu_pkg::CNT_W-1:0]  r_tx_index, n_tx_index;
    ohsu_pkg::t_phase            r_tx_phase, n_tx_phase;
    logic [2:0]                  r_tx_bit_pos, n_tx_bit_pos;
    logic                        r_tx_level, n_tx_level;
    logic                        r_tx_enable, n_tx_enable;
    logic                        r_rx_enable, n_rx_enable;
    ohsu_pkg::t_phase            r_rx_phase, n_rx_phase;
    logic [ohsu_pkg::SC_W-1:0]   r_sample_count, n_sample_count;
    logic [ohsu_pkg::HIST_W-1:0] r_sample_history, n_sample_history;
    logic [2:0]                  r_rx_bit_pos, n_rx_bit_pos;
    logic [7:0]                  r_rx_shift, n_rx_shift;
    logic [15:0]                 r_rx_counter, n_rx_counter;

    logic                        buf_wr;
    logic [7:0]                  buf_rd;
    logic [ohsu_pkg::CNT_W-1:0]  idx_inc;
    logic                        tx_done;
    logic                        rx_valid;
    logic                        rx_bit;
    ohsu_pkg::t_phase            ph_b;
    logic [7:0]                  shift_b;
    logic [2:0]                  bpos_b;
    logic [ohsu_pkg::SC_W-1:0]   cnt_b, cnt_n;
    logic [ohsu_pkg::HIST_W-1:0] hist_b, hist_n;

    // byte under transmission; index stays below the fill level while sending
    assign buf_rd  = r_tx_buffer[r_tx_index[ohsu_pkg::ADDR_W-1:0]];
    assign idx_inc = r_tx_index + 1'b1;

    // receive base values: a start edge in idle restarts the frame
    always_comb begin
        if (r_rx_phase == ohsu_pkg::PH_IDLE) begin
            ph_b    = ohsu_pkg::PH_START;
            shift_b = '0;
            bpos_b  = '0;
            cnt_b   = '0;
            hist_b  = '0;
        end else begin
            ph_b    = r_rx_phase;
            shift_b = r_rx_shift;
            bpos_b  = r_rx_bit_pos;
            cnt_b   = r_sample_count;
            hist_b  = r_sample_history;
        end
        hist_n = ohsu_pkg::HIST_W'({hist_b, i_item.rx_line});
        cnt_n  = cnt_b + 1'b1;
        rx_bit = ohsu_pkg::vote(hist_n);
    end

    // next state for one beat
    always_comb begin
        n_load_count     = r_load_count;
        n_tx_index       = r_tx_index;
        n_tx_phase       = r_tx_phase;
        n_tx_bit_pos     = r_tx_bit_pos;
        n_tx_level       = r_tx_level;
        n_tx_enable      = r_tx_enable;
        n_rx_enable      = r_rx_enable;
        n_rx_phase       = r_rx_phase;
        n_sample_count   = r_sample_count;
        n_sample_history = r_sample_history;
        n_rx_bit_pos     = r_rx_bit_pos;
        n_rx_shift       = r_rx_shift;
        n_rx_counter     = r_rx_counter;
        buf_wr           = 1'b0;
        tx_done          = 1'b0;
        rx_valid         = 1'b0;

        unique case (i_item.func)
            ohsu_pkg::FUNC_LOAD: begin
                // loads are ignored while a message is on the line
                if (!r_tx_enable) begin
                    if (r_load_count < ohsu_pkg::TX_DEPTH_N) begin
                        buf_wr       = 1'b1;
                        n_load_count = r_load_count + 1'b1;
                    end
                    if (i_item.tx_last && (n_load_count != '0)) begin
                        n_tx_enable  = 1'b1;
                        n_rx_enable  = 1'b0;
                        n_tx_index   = '0;
                        n_tx_bit_pos = '0;
                        n_tx_phase   = ohsu_pkg::PH_START;
                    end
                end
            end
            ohsu_pkg::FUNC_TX: begin
                if (r_tx_enable) begin
                    unique case (r_tx_phase)
                        ohsu_pkg::PH_START: begin
                            n_tx_level   = 1'b0;
                            n_tx_bit_pos = '0;
                            n_tx_phase   = ohsu_pkg::PH_DATA;
                        end
                        ohsu_pkg::PH_DATA: begin
                            n_tx_level = buf_rd[r_tx_bit_pos];
                            if (r_tx_bit_pos == ohsu_pkg::LAST_BIT) begin
                                n_tx_bit_pos = '0;
                                n_tx_phase   = ohsu_pkg::PH_STOP;
                            end else begin
                                n_tx_bit_pos = r_tx_bit_pos + 1'b1;
                            end
                        end
                        ohsu_pkg::PH_STOP: begin
                            n_tx_level   = 1'b1;
                            n_tx_bit_pos = '0;
                            if (idx_inc < r_load_count) begin
                                n_tx_index = idx_inc;
                                n_tx_phase = ohsu_pkg::PH_START;
                            end else begin
                                // message finished, hand the line back to rx
                                n_tx_index   = '0;
                                n_tx_phase   = ohsu_pkg::PH_IDLE;
                                n_tx_enable  = 1'b0;
                                n_rx_enable  = 1'b1;
                                n_load_count = '0;
                                tx_done      = 1'b1;
                            end
                        end
                        default: begin
                            n_tx_phase = ohsu_pkg::PH_START;
                        end
                    endcase
                end
            end
            ohsu_pkg::FUNC_RX: begin
                if (r_rx_enable &&
                    !((r_rx_phase == ohsu_pkg::PH_IDLE) && i_item.rx_line)) begin
                    n_rx_phase   = ph_b;
                    n_rx_shift   = shift_b;
                    n_rx_bit_pos = bpos_b;
                    if (cnt_n < ohsu_pkg::SPB_N) begin
                        // still collecting samples for this bit
                        n_sample_count   = cnt_n;
                        n_sample_history = hist_n;
                    end else begin
                        n_sample_count   = '0;
                        n_sample_history = '0;
                        unique case (ph_b)
                            ohsu_pkg::PH_START: begin
                                n_rx_phase   = rx_bit ? ohsu_pkg::PH_STOP
                                                      : ohsu_pkg::PH_DATA;
                                n_rx_bit_pos = '0;
                            end
                            ohsu_pkg::PH_DATA: begin
                                n_rx_shift = shift_b | (8'(rx_bit) << bpos_b);
                                if (bpos_b == ohsu_pkg::LAST_BIT) begin
                                    n_rx_bit_pos = '0;
                                    n_rx_phase   = ohsu_pkg::PH_STOP;
                                end else begin
                                    n_rx_bit_pos = bpos_b + 1'b1;
                                end
                            end
                            default: begin
                                // stop bit or stop hunting: only a high vote ends it
                                if (rx_bit) begin
                                    n_rx_counter = r_rx_counter + 1'b1;
                                    n_rx_phase   = ohsu_pkg::PH_IDLE;
                                    rx_valid     = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count     <= '0;
            r_tx_index       <= '0;
            r_tx_phase       <= ohsu_pkg::PH_IDLE;
            r_tx_bit_pos     <= '0;
            r_tx_level       <= 1'b1;
            r_tx_enable      <= 1'b0;
            r_rx_enable      <= 1'b1;
            r_rx_phase       <= ohsu_pkg::PH_IDLE;
            r_sample_count   <= '0;
            r_sample_history <= '0;
            r_rx_bit_pos     <= '0;
            r_rx_shift       <= '0;
            r_rx_counter     <= '0;
        end else if (i_fire) begin
            r_load_count     <= n_load_count;
            r_tx_index       <= n_tx_index;
            r_tx_phase       <= n_tx_phase;
            r_tx_bit_pos     <= n_tx_bit_pos;
            r_tx_level       <= n_tx_level;
            r_tx_enable      <= n_tx_enable;
            r_rx_enable      <= n_rx_enable;
            r_rx_phase       <= n_rx_phase;
            r_sample_count   <= n_sample_count;
            r_sample_history <= n_sample_history;
            r_rx_bit_pos     <= n_rx_bit_pos;
            r_rx_shift       <= n_rx_shift;
            r_rx_counter     <= n_rx_counter;
        end
    end

    // transmit buffer, written at the fill level
    always_ff @(posedge i_clk) begin
        if (i_fire && buf_wr) begin
            r_tx_buffer[r_load_count[ohsu_pkg::ADDR_W-1:0]] <= i_item.tx_byte;
        end
    end

    // result of this beat, after the update
    always_comb begin
        o_result.tx_line    = n_tx_level;
        o_result.tx_active  = n_tx_enable;
        o_result.tx_done    = tx_done;
        o_result.rx_byte    = n_rx_shift;
        o_result.rx_valid   = rx_valid;
        o_result.rx_total   = n_rx_counter;
        o_result.rx_enabled = n_rx_enable;
    end

    `OHSU_ASSERT(a_half_duplex, r_tx_enable != r_rx_enable)
    `OHSU_ASSERT_IMP(a_tx_index_range, r_tx_enable, r_tx_index < r_load_count)
    `OHSU_ASSERT_NEXT(a_done_releases, i_fire && tx_done, !r_tx_enable && r_rx_enable)
    `OHSU_ASSERT_NEXT(a_rx_valid_idle, i_fire && rx_valid, r_rx_phase == ohsu_pkg::PH_IDLE)

endmodule

`default_nettype wire

// ----- src/ohsu_skid.sv -----
// two-entry result buffer: output register plus skid register
// depends on ohsu_pkg and the defines header
`default_nettype none
`include "oversampled_half_duplex_soft_uart_top_defines.svh"

module ohsu_skid (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire ohsu_pkg::t_out_item i_data,
    output logic                     o_stall,
    output logic                     o_valid,
    output ohsu_pkg::t_out_item      o_data,
    input  wire logic                i_stall
);

    logic                r_out_valid;
    logic                r_skid_valid;
    ohsu_pkg::t_out_item r_out_data;
    ohsu_pkg::t_out_item r_skid_data;
    logic                out_take;

    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload moves
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

    `OHSU_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid)

endmodule

`default_nettype wire
